[src/wfdm_pkg.sv]
// Shared types, constants and helpers for the wall-follow drive mode controller.
package wfdm_pkg;

	localparam int SampleWidth = 16;
	localparam int SpeedWidth  = 16;
	localparam int ModeWidth   = 3;
	localparam int CfgWidth    = 16;
	localparam int CfgIdxWidth = 3;
	localparam int InDataWidth = 80;
	localparam int OutDataWidth = 40;
	localparam int UserWidth   = 2;

	localparam logic signed [SpeedWidth-1:0] SmoothSpeedQ88 = 16'sd2560;

	localparam logic [ModeWidth-1:0] MODE_NULL     = 3'd0;
	localparam logic [ModeWidth-1:0] MODE_DRIVE    = 3'd1;
	localparam logic [ModeWidth-1:0] MODE_FOLLOW_L = 3'd2;
	localparam logic [ModeWidth-1:0] MODE_FOLLOW_R = 3'd3;
	localparam logic [ModeWidth-1:0] MODE_TURN     = 3'd4;

	localparam logic [CfgIdxWidth-1:0] REG_FRONT_TH  = 3'd0;
	localparam logic [CfgIdxWidth-1:0] REG_LEFT_TH   = 3'd1;
	localparam logic [CfgIdxWidth-1:0] REG_RIGHT_TH  = 3'd2;
	localparam logic [CfgIdxWidth-1:0] REG_STRAIGHT  = 3'd3;
	localparam logic [CfgIdxWidth-1:0] REG_TURNING   = 3'd4;
	localparam logic [CfgIdxWidth-1:0] REG_BASE      = 3'd5;
	localparam logic [CfgIdxWidth-1:0] REG_TIMEOUT   = 3'd6;

	typedef struct packed {
		logic                         smooth_enabled;
		logic                         motors_enabled;
		logic [ModeWidth-1:0]         drive_mode;
		logic signed [SpeedWidth-1:0] motor_right_drive;
		logic signed [SpeedWidth-1:0] motor_left_drive;
	} result_t;

	function automatic logic signed [SpeedWidth-1:0] sat_speed(
		input logic signed [SpeedWidth:0] v
	);
		logic signed [SpeedWidth-1:0] r;
		if (v[SpeedWidth] != v[SpeedWidth-1]) begin
			r = v[SpeedWidth] ? {1'b1, {(SpeedWidth-1){1'b0}}}
			                  : {1'b0, {(SpeedWidth-1){1'b1}}};
		end else begin
			r = v[SpeedWidth-1:0];
		end
		return r;
	endfunction

endpackage

[src/wfdm_out_buf.sv]
// Two-entry result buffer: output register plus skid stage.
module wfdm_out_buf
	import wfdm_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  result_t in_data,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_data
);

	logic    main_valid_q;
	logic    skid_valid_q;
	result_t main_data_q;
	result_t skid_data_q;
	logic    take;
	logic    push;

	assign in_ready  = !skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_data  = main_data_q;
	assign take      = main_valid_q && out_ready;
	assign push      = in_valid && !skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (main_valid_q && !take) begin
				skid_valid_q <= 1'b1;
			end else begin
				main_valid_q <= 1'b1;
			end
		end else if (take) begin
			main_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take) begin
				main_data_q <= skid_data_q;
			end
		end else if (push) begin
			if (main_valid_q && !take) begin
				skid_data_q <= in_data;
			end else begin
				main_data_q <= in_data;
			end
		end
	end

	a_skid_needs_main: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> main_valid_q)
		else $error("skid entry held without output entry");

	a_push_shows: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> main_valid_q)
		else $error("accepted result not presented");

	a_stall_fills_skid: assert property (@(posedge clk) disable iff (!arst_n)
		(push && main_valid_q && !out_ready) |=> !in_ready)
		else $error("stalled push did not land in skid stage");

endmodule

[src/wall_follow_drive_mode_controller.sv]
// Top level: button edges, mode transitions and motor drive formation.
// Each accepted transaction is one control period; its result is registered into the output
// buffer and shown on the master side, and a new transaction can be accepted every cycle unless
// both buffer entries are full. The whole period (edges, mode transition, drive sums and
// saturation) is one pass of compares and 17-bit adds into the result register; a two-entry
// output buffer lets the slave side keep accepting while one result waits, and tready drops only
// when both entries are full. The configuration port takes writes at any cycle with no wait.
module wall_follow_drive_mode_controller
	import wfdm_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	// sample_front[15:0], sample_left[31:16], sample_right[47:32],
	// steer_left[63:48], steer_right[79:64]
	input  logic [InDataWidth-1:0]  s_tdata,
	// power_button[0], light_button[1]
	input  logic [UserWidth-1:0]    s_tuser,
	output logic                    m_tvalid,
	input  logic                    m_tready,
	// motor_left_drive[15:0], motor_right_drive[31:16], drive_mode[34:32], zero[39:35]
	output logic [OutDataWidth-1:0] m_tdata,
	// motors_enabled[0], smooth_enabled[1]
	output logic [UserWidth-1:0]    m_tuser,
	input  logic                    cfg_we,
	input  logic [CfgIdxWidth-1:0]  cfg_index,
	input  logic [CfgWidth-1:0]     cfg_data
);

	logic [SampleWidth-1:0]       front_th_q, left_th_q, right_th_q;
	logic signed [SpeedWidth-1:0] straight_q, turning_q, base_q;
	logic [CfgWidth-1:0]          timeout_q;

	logic [ModeWidth-1:0] mode_q;
	logic [15:0]          wall_cnt_q;
	logic                 motors_q, smooth_q, latch_q, power_prev_q, light_prev_q;

	logic [SampleWidth-1:0]       smp_f, smp_l, smp_r;
	logic signed [SpeedWidth-1:0] stl, str;
	logic                         pb, lb, accept;
	logic                         motors_n, smooth_rise, smooth_n, latch_n;
	logic                         front, lw, rw, clear, to_fl, to_fr, follow;
	logic [ModeWidth-1:0]         mode_n;
	logic [15:0]                  cnt_base, cnt_n;
	logic signed [SpeedWidth-1:0] base_eff, ml, mr;
	logic signed [SpeedWidth:0]   base_x, stl_x, str_x, ml_x, mr_x;
	result_t                      res;
	result_t                      out_res;
	logic                         buf_ready;

	assign smp_f  = s_tdata[15:0];
	assign smp_l  = s_tdata[31:16];
	assign smp_r  = s_tdata[47:32];
	assign stl    = s_tdata[63:48];
	assign str    = s_tdata[79:64];
	assign pb     = s_tuser[0];
	assign lb     = s_tuser[1];
	assign accept = s_tvalid && buf_ready;
	assign s_tready = buf_ready;

	assign motors_n    = motors_q ^ (pb & ~power_prev_q);
	assign smooth_rise = lb & ~light_prev_q;
	assign smooth_n    = smooth_q ^ smooth_rise;
	assign latch_n     = latch_q | (smooth_rise & smooth_n);

	assign front  = (smp_f > front_th_q) && (!smooth_n || ((smp_f > smp_l) && (smp_f > smp_r)));
	assign lw     = smp_l > left_th_q;
	assign rw     = smp_r > right_th_q;
	assign clear  = !front && !lw && !rw;
	assign to_fl  = !front && lw && (smp_l > smp_r);
	assign to_fr  = !front && rw && (smp_r >= smp_l);
	assign follow = (mode_q == MODE_FOLLOW_L) || (mode_q == MODE_FOLLOW_R);

	always_comb begin
		mode_n = mode_q;
		unique case (mode_q)
			MODE_DRIVE: begin
				if (to_fl) mode_n = MODE_FOLLOW_L;
				else if (front) mode_n = MODE_TURN;
				else if (to_fr) mode_n = MODE_FOLLOW_R;
			end
			MODE_TURN: begin
				if (clear) mode_n = MODE_DRIVE;
				else if (to_fl) mode_n = MODE_FOLLOW_L;
				else if (to_fr) mode_n = MODE_FOLLOW_R;
			end
			MODE_FOLLOW_L, MODE_FOLLOW_R: begin
				if (clear) begin
					if (wall_cnt_q >= timeout_q) mode_n = MODE_DRIVE;
				end else if (front) begin
					mode_n = MODE_TURN;
				end
			end
			default: mode_n = MODE_DRIVE;
		endcase
	end

	assign cnt_base = (follow && !clear) ? 16'd0 : wall_cnt_q;
	assign cnt_n    = (cnt_base == 16'hFFFF) ? cnt_base : cnt_base + 16'd1;

	assign base_eff = latch_n ? SmoothSpeedQ88 : base_q;
	assign base_x   = {base_eff[SpeedWidth-1], base_eff};
	assign stl_x    = {stl[SpeedWidth-1], stl};
	assign str_x    = {str[SpeedWidth-1], str};

	always_comb begin
		ml_x = '0;
		mr_x = '0;
		case (mode_n)
			MODE_DRIVE: begin
				ml_x = {straight_q[SpeedWidth-1], straight_q};
				mr_x = {straight_q[SpeedWidth-1], straight_q};
			end
			MODE_FOLLOW_L: begin
				ml_x = base_x - stl_x;
				mr_x = base_x + stl_x;
			end
			MODE_FOLLOW_R: begin
				ml_x = base_x + str_x;
				mr_x = base_x - str_x;
			end
			MODE_TURN: begin
				if (smp_l > smp_r) ml_x = {turning_q[SpeedWidth-1], turning_q};
				else mr_x = {turning_q[SpeedWidth-1], turning_q};
			end
			default: begin
				ml_x = '0;
				mr_x = '0;
			end
		endcase
	end

	assign ml = sat_speed(ml_x);
	assign mr = sat_speed(mr_x);

	assign res.smooth_enabled    = smooth_n;
	assign res.motors_enabled    = motors_n;
	assign res.drive_mode        = mode_n;
	assign res.motor_right_drive = mr;
	assign res.motor_left_drive  = ml;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_NULL;
			wall_cnt_q   <= '0;
			motors_q     <= 1'b0;
			smooth_q     <= 1'b0;
			latch_q      <= 1'b0;
			power_prev_q <= 1'b0;
			light_prev_q <= 1'b0;
		end else begin
			if (accept) begin
				mode_q       <= mode_n;
				wall_cnt_q   <= cnt_n;
				motors_q     <= motors_n;
				smooth_q     <= smooth_n;
				power_prev_q <= pb;
				light_prev_q <= lb;
			end
			if (cfg_we && (cfg_index == REG_BASE)) begin
				latch_q <= 1'b0;
			end else if (accept) begin
				latch_q <= latch_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_th_q <= 16'd1024;
			left_th_q  <= 16'd1024;
			right_th_q <= 16'd1024;
			straight_q <= '0;
			turning_q  <= '0;
			base_q     <= '0;
			timeout_q  <= 16'd300;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FRONT_TH: front_th_q <= cfg_data;
				REG_LEFT_TH:  left_th_q  <= cfg_data;
				REG_RIGHT_TH: right_th_q <= cfg_data;
				REG_STRAIGHT: straight_q <= cfg_data;
				REG_TURNING:  turning_q  <= cfg_data;
				REG_BASE:     base_q     <= cfg_data;
				REG_TIMEOUT:  timeout_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	wfdm_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (buf_ready),
		.in_data   (res),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (out_res)
	);

	assign m_tdata = {5'b0, out_res.drive_mode, out_res.motor_right_drive,
	                  out_res.motor_left_drive};
	assign m_tuser = {out_res.smooth_enabled, out_res.motors_enabled};

	a_null_to_drive: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (mode_q == MODE_NULL)) |=> (mode_q == MODE_DRIVE))
		else $error("null mode did not advance to drive");

	a_wall_clears_count: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && follow && !clear) |=> (wall_cnt_q == 16'd1))
		else $error("visible wall in follow mode did not restart count");

	a_turn_one_motor: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tdata[34:32] == MODE_TURN)) |->
		((m_tdata[15:0] == 16'd0) || (m_tdata[31:16] == 16'd0)))
		else $error("turn mode drives both motors");

endmodule
